/* sv/btb2l_pkg.sv */
// ----------------------------------------------------------------------------
// btb2l_pkg
// Shared constants and types for the two-level branch predictor with BTB.
// ----------------------------------------------------------------------------
package btb2l_pkg;

  localparam int BTB_ENTRIES = 32;
  localparam int LINE_W      = $clog2(BTB_ENTRIES);
  localparam int MAX_HISTORY = 8;
  localparam int HIST_W      = MAX_HISTORY;
  localparam int TABLE_SIZE  = 1 << MAX_HISTORY;
  localparam int TAG_W       = 30;
  localparam int CTR_AW      = LINE_W + HIST_W;
  localparam int PADDR_W     = 5;

  // register indexes on the configuration port
  localparam logic [2:0] REG_HISTORY_BITS   = 3'd0;
  localparam logic [2:0] REG_TAG_BITS       = 3'd1;
  localparam logic [2:0] REG_COUNTER_INIT   = 3'd2;
  localparam logic [2:0] REG_GLOBAL_HISTORY = 3'd3;
  localparam logic [2:0] REG_GLOBAL_TABLE   = 3'd4;
  localparam logic [2:0] REG_SHARE_MODE     = 3'd5;

  // operation codes
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // share modes
  localparam logic [1:0] SHARE_NONE = 2'd0;
  localparam logic [1:0] SHARE_LOW  = 2'd1;
  localparam logic [1:0] SHARE_HIGH = 2'd2;

  // counter value of a per-line table that was never refilled
  localparam logic [1:0] CTR_RESET = 2'd1;

  typedef logic [HIST_W-1:0] hist_t;

  // one line of the target buffer
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [31:0]      target;
    hist_t            history;
  } line_t;

endpackage

/* sv/btb_two_level_branch_predictor.sv */
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor
// Direct-mapped BTB with per-line or shared history and 2-bit counter tables.
// ----------------------------------------------------------------------------
// Flow: ST_LOOK, then ST_FILL (refill sweep) if needed, then ST_CNT (counter read, then
//   use); out_valid is registered and high for one cycle. busy blocks new items until
//   done. Updates with per-line tables refill on a miss or on a never refilled row.
// Reset (rst_n low, synchronous): lines invalid, histories and totals zero,
//   counters read as their reset value; no clearing pass is needed.
// The receiver cannot stall: each result shows for exactly one cycle.
module btb_two_level_branch_predictor (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [31:0]                    in_pc,
  input  logic [31:0]                    in_actual_target,
  input  logic                           in_actual_taken,
  input  logic [31:0]                    in_guessed_target,
  // result channel
  output logic                           out_valid,
  output logic                           out_predict_taken,
  output logic [31:0]                    out_next_address,
  output logic                           out_flushed,
  output logic [31:0]                    out_branch_total,
  output logic [31:0]                    out_flush_total,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btb2l_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import btb2l_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_CNT  = 2'd3;

  // configuration registers
  logic [3:0] history_bits_r;
  logic [4:0] tag_bits_r;
  logic [1:0] counter_init_r;
  logic       global_history_r;
  logic       global_table_r;
  logic [1:0] share_mode_r;

  // control and item registers
  logic [1:0]        state_r, state_nxt;
  logic              rdc_r;
  logic              op_r;
  logic [31:0]       pc_r, tgt_r, guess_r;
  logic              taken_r;
  logic              hit_r;
  hist_t             hist_line_r, hist_eff_r, k_r;
  logic [HIST_W-1:0] fill_cnt_r;
  logic [31:0]       branch_cnt_r, flush_cnt_r;
  hist_t             shared_hist_r;
  logic [BTB_ENTRIES-1:0] line_vld_r, row_vld_r;
  logic [TABLE_SIZE-1:0]  sh_vld_r;

  // output registers
  logic        out_valid_r;
  logic        out_pt_r, out_fl_r;
  logic [31:0] out_na_r;

  // memories
  line_t      line_mem [BTB_ENTRIES];
  logic [1:0] ctr_mem  [1 << CTR_AW];
  logic [1:0] sh_mem   [TABLE_SIZE];
  line_t      line_rd_r;
  logic [1:0] ctr_rd_r, sh_rd_r;

  logic              cfg_wr;
  logic [2:0]        cfg_idx;
  logic              accept;
  logic [LINE_W-1:0] line_idx;
  logic [LINE_W-1:0] rd_line;
  logic [3:0]        eff_len;
  hist_t             hmask;
  logic [TAG_W-1:0]  tag_now;
  logic              hit_now;
  hist_t             hist_line_now, hist_eff_now, xor_now, k_now;
  logic [1:0]        cnt_cur, cnt_new;
  logic              pred, skip, fl;
  hist_t             hist_shift;
  logic              miss_fill;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign line_idx = pc_r[LINE_W+1:2];
  assign rd_line  = (state_r == ST_IDLE) ? in_pc[LINE_W+1:2] : line_idx;

  // effective history length and mask
  assign eff_len = (history_bits_r > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : history_bits_r;
  assign hmask   = HIST_W'((9'd1 << eff_len) - 9'd1);

  // tag of the current pc
  always_comb begin
    tag_now = pc_r[31:2];
    if (tag_bits_r < 5'd30) begin
      tag_now = pc_r[31:2] & TAG_W'((31'd1 << tag_bits_r) - 31'd1);
    end
  end

  // lookup: hit, history and counter index
  always_comb begin
    hit_now       = line_vld_r[line_idx] && (line_rd_r.tag == tag_now);
    hist_line_now = line_vld_r[line_idx] ? line_rd_r.history : '0;
    if (global_history_r) begin
      hist_eff_now = shared_hist_r;
    end else if (op_r == OP_UPDATE && !hit_now) begin
      hist_eff_now = '0;
    end else begin
      hist_eff_now = hist_line_now;
    end
    xor_now = '0;
    if (global_table_r) begin
      case (share_mode_r)
        SHARE_LOW:  xor_now = pc_r[HIST_W+1:2];
        SHARE_HIGH: xor_now = pc_r[HIST_W+14:15];
        default:    xor_now = '0;
      endcase
    end
    k_now     = (hist_eff_now ^ xor_now) & hmask;
    // refill the row on replacement, or before the first write to a row never refilled
    miss_fill = (op_r == OP_UPDATE) && !global_table_r &&
                (!hit_now || !row_vld_r[line_idx]);
  end

  // counter evaluation and flush decision
  always_comb begin
    if (global_table_r) begin
      cnt_cur = sh_vld_r[k_r] ? sh_rd_r : counter_init_r;
    end else begin
      cnt_cur = row_vld_r[line_idx] ? ctr_rd_r : CTR_RESET;
    end
    pred    = cnt_cur[1];
    cnt_new = cnt_cur;
    if (taken_r) begin
      if (cnt_cur != 2'd3) cnt_new = cnt_cur + 2'd1;
    end else begin
      if (cnt_cur != 2'd0) cnt_new = cnt_cur - 2'd1;
    end
    skip = !taken_r && pred && (guess_r == pc_r + 32'd4);
    if (hit_r) begin
      fl = !skip && ((taken_r != pred) || (taken_r && tgt_r != guess_r));
    end else begin
      fl = taken_r;
    end
    hist_shift = ((hist_eff_r << 1) | HIST_W'(taken_r)) & hmask;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = miss_fill ? ST_FILL : ST_CNT;
      ST_FILL: if (fill_cnt_r == '1) state_nxt = ST_CNT;
      ST_CNT:  if (rdc_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      rdc_r            <= 1'b0;
      fill_cnt_r       <= '0;
      branch_cnt_r     <= '0;
      flush_cnt_r      <= '0;
      shared_hist_r    <= '0;
      line_vld_r       <= '0;
      row_vld_r        <= '0;
      sh_vld_r         <= '0;
      out_valid_r      <= 1'b0;
      history_bits_r   <= 4'd1;
      tag_bits_r       <= 5'd0;
      counter_init_r   <= 2'd1;
      global_history_r <= 1'b0;
      global_table_r   <= 1'b0;
      share_mode_r     <= SHARE_NONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_CNT) && rdc_r;
      // configuration writes
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_HISTORY_BITS:   history_bits_r   <= pwdata[3:0];
          REG_TAG_BITS:       tag_bits_r       <= pwdata[4:0];
          REG_COUNTER_INIT: begin
            counter_init_r <= pwdata[1:0];
            sh_vld_r       <= '0;
          end
          REG_GLOBAL_HISTORY: global_history_r <= pwdata[0];
          REG_GLOBAL_TABLE:   global_table_r   <= pwdata[0];
          REG_SHARE_MODE:     share_mode_r     <= pwdata[1:0];
          default: ;
        endcase
      end
      // advance the refill sweep
      if (state_r == ST_LOOK) begin
        fill_cnt_r <= '0;
        rdc_r      <= 1'b0;
      end
      if (state_r == ST_FILL) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
        if (fill_cnt_r == '1) row_vld_r[line_idx] <= 1'b1;
      end
      // CNT with rdc_r low issues the counter read; with rdc_r high it consumes it
      if (state_r == ST_CNT && !rdc_r) rdc_r <= 1'b1;
      if (state_r == ST_CNT && rdc_r) begin
        if (op_r == OP_UPDATE) begin
          branch_cnt_r <= branch_cnt_r + 32'd1;
          if (fl) flush_cnt_r <= flush_cnt_r + 32'd1;
          line_vld_r[line_idx] <= 1'b1;
          if (global_table_r) sh_vld_r[k_r] <= 1'b1;
          if (global_history_r) shared_hist_r <= hist_shift;
        end
      end
    end
  end

  // item and lookup payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      pc_r    <= in_pc;
      tgt_r   <= in_actual_target;
      taken_r <= in_actual_taken;
      guess_r <= in_guessed_target;
    end
    if (state_r == ST_LOOK) begin
      hit_r       <= hit_now;
      hist_line_r <= hist_line_now;
      hist_eff_r  <= hist_eff_now;
      k_r         <= k_now;
    end
    // predict fields only on a predict beat, flush flag only on an update beat
    if (state_r == ST_CNT && rdc_r) begin
      out_pt_r <= (op_r == OP_PREDICT) && hit_r && pred;
      out_na_r <= (op_r != OP_PREDICT) ? '0 :
                  (hit_r && pred) ? line_rd_r.target : pc_r + 32'd4;
      out_fl_r <= (op_r == OP_UPDATE) && fl;
    end
  end

  // line memory: read every cycle, write back on update
  always_ff @(posedge clk) begin
    line_rd_r <= line_mem[rd_line];
    if (state_r == ST_CNT && rdc_r && op_r == OP_UPDATE) begin
      line_mem[line_idx] <= '{tag: tag_now, target: tgt_r,
                              history: global_history_r ? hist_line_r : hist_shift};
    end
  end

  // per-line counter memory: refill sweep and counter write-back
  always_ff @(posedge clk) begin
    ctr_rd_r <= ctr_mem[{line_idx, k_r}];
    if (state_r == ST_FILL) begin
      ctr_mem[{line_idx, fill_cnt_r}] <= hit_r ? CTR_RESET : counter_init_r;
    end else if (state_r == ST_CNT && rdc_r && op_r == OP_UPDATE && !global_table_r) begin
      ctr_mem[{line_idx, k_r}] <= cnt_new;
    end
  end

  // shared counter memory
  always_ff @(posedge clk) begin
    sh_rd_r <= sh_mem[k_r];
    if (state_r == ST_CNT && rdc_r && op_r == OP_UPDATE && global_table_r) begin
      sh_mem[k_r] <= cnt_new;
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_HISTORY_BITS:   prdata = 32'(history_bits_r);
      REG_TAG_BITS:       prdata = 32'(tag_bits_r);
      REG_COUNTER_INIT:   prdata = 32'(counter_init_r);
      REG_GLOBAL_HISTORY: prdata = 32'(global_history_r);
      REG_GLOBAL_TABLE:   prdata = 32'(global_table_r);
      REG_SHARE_MODE:     prdata = 32'(share_mode_r);
      default:            prdata = '0;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_pt_r;
  assign out_next_address  = out_na_r;
  assign out_flushed       = out_fl_r;
  assign out_branch_total  = branch_cnt_r;
  assign out_flush_total   = flush_cnt_r;

`ifndef SYNTHESIS
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_fill_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FILL && fill_cnt_r == '1 |=> state_r == ST_CNT && row_vld_r[line_idx])
    else $error("refill sweep did not finish");
  a_flush_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flushed |-> $stable(flush_cnt_r))
    else $error("flush total moved without a flush");
`endif

endmodule
